>>> sv/wildcard_star_pattern_matcher_defines.svh
// Assertion macros shared by the matcher RTL.
`ifndef WILDCARD_STAR_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_STAR_PATTERN_MATCHER_DEFINES_SVH
`ifndef SYNTH
// Checked only while reset is low.
`define WSPM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, including during reset.
`define WSPM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define WSPM_ASSERT(lbl, prop, msg)
`define WSPM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> sv/wspm_pkg.sv
// Shared constants, command codes and control structs of the pattern matcher.
package wspm_pkg;

   // Default number of pattern token slots.
   localparam int PATTERN_MAX_DEF = 32;

   // Fixed field widths.
   localparam int CHAR_W  = 8;
   localparam int TIDX_W  = 5;
   localparam int COUNT_W = 6;

   // Command codes carried by each input transfer.
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_TEXT  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Execute-stage control handed to the match core.
   typedef struct packed {
      logic              fire;
      cmd_type           cmd;
      logic [CHAR_W-1:0] text_ch;
   } exec_type;

   // Token table write request.
   typedef struct packed {
      logic              en;
      logic [TIDX_W-1:0] idx;
      logic [CHAR_W-1:0] ch;
      logic              any;
      logic              star;
   } tok_wr_type;

endpackage

>>> sv/wspm_token_table.sv
// Pattern token storage: one character and two flags per token slot.
module wspm_token_table #(
   parameter int PATTERN_MAX = wspm_pkg::PATTERN_MAX_DEF
) (
   input  logic                                        clock,
   input  wspm_pkg::tok_wr_type                        tok_wr,
   output logic [PATTERN_MAX-1:0][wspm_pkg::CHAR_W-1:0] tok_ch,
   output logic [PATTERN_MAX-1:0]                      tok_any,
   output logic [PATTERN_MAX-1:0]                      tok_star
);

   logic [PATTERN_MAX-1:0][wspm_pkg::CHAR_W-1:0] ch_ff;
   logic [PATTERN_MAX-1:0]                       any_ff;
   logic [PATTERN_MAX-1:0]                       star_ff;

   // Each slot is written when the load index selects it; other indexes are dropped.
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_slot
      always_ff @(posedge clock) begin
         if (tok_wr.en && (int'(tok_wr.idx) == i)) begin
            ch_ff[i]   <= tok_wr.ch;
            any_ff[i]  <= tok_wr.any;
            star_ff[i] <= tok_wr.star;
         end
      end
   end

   assign tok_ch   = ch_ff;
   assign tok_any  = any_ff;
   assign tok_star = star_ff;

endmodule

>>> sv/wspm_closure.sv
// Closure of a position set across starred tokens, done as one carry chain.
module wspm_closure #(
   parameter int PATTERN_MAX = wspm_pkg::PATTERN_MAX_DEF
) (
   input  logic [PATTERN_MAX:0]   pos_in,
   input  logic [PATTERN_MAX-1:0] star,
   input  logic [PATTERN_MAX:0]   mask,
   output logic [PATTERN_MAX:0]   closed
);

   localparam int W = PATTERN_MAX + 1;

   logic [W-1:0] pos_m;
   logic [W-1:0] prop;
   logic [W-1:0] gen;
   logic [W-1:0] sum;
   logic [W-1:0] carry;

   // A starred token in use passes an active position on to the next one.
   // Generate is an active starred position and propagate is a starred one,
   // so the adder's carries are exactly the positions reached by skipping.
   always_comb begin
      pos_m  = pos_in & mask;
      prop   = {1'b0, star & mask[W-1:1]};
      gen    = prop & pos_m;
      sum    = prop + gen;
      carry  = sum ^ prop ^ gen;
      closed = (pos_m | carry) & mask;
   end

endmodule

>>> sv/wspm_match_core.sv
// Active position state and the per-character position update.
module wspm_match_core #(
   parameter int PATTERN_MAX = wspm_pkg::PATTERN_MAX_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  wspm_pkg::exec_type                          exec,
   input  wspm_pkg::tok_wr_type                        tok_wr,
   input  logic [wspm_pkg::COUNT_W-1:0]                tc_cur,
   input  logic [wspm_pkg::COUNT_W-1:0]                tc_next,
   input  logic [PATTERN_MAX-1:0][wspm_pkg::CHAR_W-1:0] tok_ch,
   input  logic [PATTERN_MAX-1:0]                      tok_any,
   input  logic [PATTERN_MAX-1:0]                      tok_star,
   output logic                                        matched
);

   localparam int W  = PATTERN_MAX + 1;
   localparam int NW = $clog2(PATTERN_MAX + 1);
   localparam logic [W-1:0] START_POS = {{PATTERN_MAX{1'b0}}, 1'b1};

   // last_ff is the set left by the last start or character; cur_ff is that
   // set closed under the tokens and count in force now.
   logic [W-1:0]           last_ff, last_in;
   logic [W-1:0]           cur_ff, cur_in;
   logic [NW-1:0]          n_cur, n_next;
   logic [W-1:0]           mask_cur, mask_next;
   logic [PATTERN_MAX-1:0] hit;
   logic [PATTERN_MAX-1:0] star_view;
   logic [W-1:0]           adv;
   logic [W-1:0]           step_src;
   logic [W-1:0]           step_pos;
   logic [W-1:0]           hold_pos;
   logic                   step_take;

   // Tokens in use, limited to the table size, and the matching position masks.
   always_comb begin
      n_cur  = (int'(tc_cur) > PATTERN_MAX) ? NW'(PATTERN_MAX) : tc_cur[NW-1:0];
      n_next = (int'(tc_next) > PATTERN_MAX) ? NW'(PATTERN_MAX) : tc_next[NW-1:0];
      for (int i = 0; i < W; i++) begin
         mask_cur[i]  = (i <= int'(n_cur));
         mask_next[i] = (i <= int'(n_next));
      end
   end

   // Advance every active position whose token accepts the character.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         hit[i] = cur_ff[i] & mask_cur[i+1] &
                  (tok_any[i] | (tok_ch[i] == exec.text_ch));
      end
      adv[0] = hit[0] & tok_star[0];
      for (int i = 1; i < PATTERN_MAX; i++) begin
         adv[i] = (hit[i] & tok_star[i]) | (hit[i-1] & ~tok_star[i-1]);
      end
      adv[PATTERN_MAX] = hit[PATTERN_MAX-1] & ~tok_star[PATTERN_MAX-1];
      step_src = (exec.cmd == wspm_pkg::CMD_START) ? START_POS : adv;
   end

   // Star flags as they stand after a load in this cycle.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         star_view[i] = (tok_wr.en && (int'(tok_wr.idx) == i)) ? tok_wr.star : tok_star[i];
      end
   end

   wspm_closure #(.PATTERN_MAX(PATTERN_MAX)) u_clo_step (
      .pos_in (step_src),
      .star   (tok_star),
      .mask   (mask_cur),
      .closed (step_pos)
   );

   wspm_closure #(.PATTERN_MAX(PATTERN_MAX)) u_clo_hold (
      .pos_in (last_ff),
      .star   (star_view),
      .mask   (mask_next),
      .closed (hold_pos)
   );

   // A start or a character replaces the set; otherwise the current set is
   // re-closed so loads and count changes are seen by the next character.
   always_comb begin
      step_take = exec.fire &&
                  ((exec.cmd == wspm_pkg::CMD_START) || (exec.cmd == wspm_pkg::CMD_TEXT));
      last_in   = step_take ? step_pos : last_ff;
      cur_in    = step_take ? step_pos : hold_pos;
      matched   = step_take && step_pos[n_cur];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= START_POS;
         cur_ff  <= START_POS;
      end else begin
         last_ff <= last_in;
         cur_ff  <= cur_in;
      end
   end

endmodule

>>> sv/wildcard_star_pattern_matcher.sv
// Top level of the wildcard and star pattern matcher.
//
//   Channel   Ports                     Direction   Moves
//   req       req_valid / req_ready     in          one command with its fields
//   rsp       rsp_valid / rsp_ready     out         one matched bit per command
//   csr       csr_wr_en / csr_wr_data   in          token count, no wait
//
// Each command passes through the input register, then through the position
// update into the result register. One command per cycle is sustained while
// the result is not stalled; the position set is updated by a single carry
// chain per command. Reset clears the count, the position set and both
// pipeline registers; the token table keeps its contents until loaded.
// A stalled result holds the input register, which then holds req_ready low.
module wildcard_star_pattern_matcher #(
   parameter int PATTERN_MAX = wspm_pkg::PATTERN_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [wspm_pkg::TIDX_W-1:0]         req_token_index,
   input  logic [wspm_pkg::CHAR_W-1:0]         req_token_char,
   input  logic                                req_token_any,
   input  logic                                req_token_star,
   input  logic [wspm_pkg::CHAR_W-1:0]         req_text_char,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_matched,
   input  logic                                csr_wr_en,
   input  logic [wspm_pkg::COUNT_W-1:0]        csr_wr_data
);

`include "wildcard_star_pattern_matcher_defines.svh"

   logic                                        in_valid_ff, in_valid_in;
   wspm_pkg::cmd_type                           in_cmd_ff;
   logic [wspm_pkg::TIDX_W-1:0]                 in_idx_ff;
   logic [wspm_pkg::CHAR_W-1:0]                 in_tch_ff;
   logic                                        in_any_ff;
   logic                                        in_star_ff;
   logic [wspm_pkg::CHAR_W-1:0]                 in_xch_ff;
   logic                                        rsp_valid_ff, rsp_valid_in;
   logic                                        rsp_matched_ff;
   logic [wspm_pkg::COUNT_W-1:0]                tc_ff, tc_in;
   logic                                        req_take;
   logic                                        stage_go;
   logic                                        core_matched;
   wspm_pkg::exec_type                          exec;
   wspm_pkg::tok_wr_type                        tok_wr;
   logic [PATTERN_MAX-1:0][wspm_pkg::CHAR_W-1:0] tok_ch;
   logic [PATTERN_MAX-1:0]                      tok_any;
   logic [PATTERN_MAX-1:0]                      tok_star;

   // Handshake: the input register executes whenever the result register is free.
   always_comb begin
      stage_go     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || stage_go;
      req_take     = req_valid && req_ready;
      in_valid_in  = req_take || (in_valid_ff && !stage_go);
      rsp_valid_in = stage_go || (rsp_valid_ff && !rsp_ready);
      tc_in        = csr_wr_en ? csr_wr_data : tc_ff;
   end

   // Control handed to the table and the core.
   always_comb begin
      exec.fire     = stage_go;
      exec.cmd      = in_cmd_ff;
      exec.text_ch  = in_xch_ff;
      tok_wr.en     = stage_go && (in_cmd_ff == wspm_pkg::CMD_LOAD);
      tok_wr.idx    = in_idx_ff;
      tok_wr.ch     = in_tch_ff;
      tok_wr.any    = in_any_ff;
      tok_wr.star   = in_star_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tc_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tc_ff        <= tc_in;
      end
   end

   // Input payload register, loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= wspm_pkg::cmd_type'(req_cmd);
         in_idx_ff  <= req_token_index;
         in_tch_ff  <= req_token_char;
         in_any_ff  <= req_token_any;
         in_star_ff <= req_token_star;
         in_xch_ff  <= req_text_char;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (stage_go) begin
         rsp_matched_ff <= core_matched;
      end
   end

   wspm_token_table #(.PATTERN_MAX(PATTERN_MAX)) u_table (
      .clock    (clock),
      .tok_wr   (tok_wr),
      .tok_ch   (tok_ch),
      .tok_any  (tok_any),
      .tok_star (tok_star)
   );

   wspm_match_core #(.PATTERN_MAX(PATTERN_MAX)) u_core (
      .clock    (clock),
      .reset    (reset),
      .exec     (exec),
      .tok_wr   (tok_wr),
      .tc_cur   (tc_ff),
      .tc_next  (tc_in),
      .tok_ch   (tok_ch),
      .tok_any  (tok_any),
      .tok_star (tok_star),
      .matched  (core_matched)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // Both pipeline registers are empty after reset.
   `WSPM_ASSERT_RST(a_reset_empty, reset |=> (!rsp_valid && !in_valid_ff), "pipeline not empty after reset")
   // The input side stalls only behind a full, stalled result register.
   `WSPM_ASSERT(a_stall_cause, !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready), "input stalled without cause")
   // A token load never reports a match.
   `WSPM_ASSERT(a_load_nomatch, (stage_go && (in_cmd_ff == wspm_pkg::CMD_LOAD)) |=> (rsp_valid && !rsp_matched), "load reported a match")
   // An empty pattern matches the empty text.
   `WSPM_ASSERT(a_empty_match, (stage_go && (in_cmd_ff == wspm_pkg::CMD_START) && (tc_ff == '0)) |=> rsp_matched, "empty pattern missed empty text")

endmodule

>>> test/wildcard_star_pattern_matcher_tb.sv
// Self-checking testbench for the wildcard and star pattern matcher.
module wildcard_star_pattern_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = wspm_pkg::PATTERN_MAX_DEF;
   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_PCT = 34;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SHOW_LIMIT = 10;
   localparam logic [7:0] LETTER_A = "a";
   localparam logic [SLOTS:0] START_SET = (SLOTS + 1)'(1);

   // One command as offered on the request channel.
   typedef struct {
      wspm_pkg::cmd_type                 cmd;
      logic [wspm_pkg::TIDX_W-1:0]       idx;
      logic [wspm_pkg::CHAR_W-1:0]       tch;
      logic                              any;
      logic                              star;
      logic [wspm_pkg::CHAR_W-1:0]       txt;
   } request_type;

   typedef struct {
      logic        hit;
      int unsigned seq;
   } expected_match_type;

   typedef logic [7:0] text_type[$];

   // Tracks the token table and the active position set, and checks each matched bit.
   class match_scoreboard;
      logic [wspm_pkg::CHAR_W-1:0]  tok_char [SLOTS];
      bit                           tok_any [SLOTS];
      bit                           tok_star [SLOTS];
      logic [SLOTS:0]               live;
      logic [wspm_pkg::COUNT_W-1:0] token_count;
      expected_match_type           expected_hits[$];
      int unsigned                  accepted;
      int unsigned                  handled;
      int unsigned                  errors;

      function new();
         live = START_SET;
         token_count = '0;
         accepted = 0;
         handled = 0;
         errors = 0;
      endfunction

      function void set_token_count(logic [wspm_pkg::COUNT_W-1:0] v);
         token_count = v;
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= SHOW_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, what);
      endfunction

      // Positions reachable by skipping starred tokens, limited to 0..n.
      function logic [SLOTS:0] close_over_stars(logic [SLOTS:0] set, int n);
         for (int i = 0; i < n; i++) begin
            if (set[i] && tok_star[i])
               set[i+1] = 1'b1;
         end
         for (int i = n + 1; i <= SLOTS; i++)
            set[i] = 1'b0;
         return set;
      endfunction

      // Works out the matched bit of one accepted command and updates the state.
      function logic predict_match(request_type r);
         int n;
         logic [SLOTS:0] cur;
         logic [SLOTS:0] nxt;
         logic hit;
         n = (token_count > SLOTS) ? SLOTS : int'(token_count);
         hit = 1'b0;
         case (r.cmd)
            wspm_pkg::CMD_LOAD: begin
               tok_char[r.idx] = r.tch;
               tok_any[r.idx] = r.any;
               tok_star[r.idx] = r.star;
            end
            wspm_pkg::CMD_START: begin
               live = close_over_stars(START_SET, n);
               hit = live[n];
            end
            wspm_pkg::CMD_TEXT: begin
               cur = close_over_stars(live, n);
               nxt = '0;
               for (int i = 0; i < n; i++) begin
                  if (cur[i] && (tok_any[i] || tok_char[i] == r.txt)) begin
                     if (tok_star[i])
                        nxt[i] = 1'b1;
                     else
                        nxt[i+1] = 1'b1;
                  end
               end
               live = close_over_stars(nxt, n);
               hit = live[n];
            end
            default: hit = 1'b0;
         endcase
         return hit;
      endfunction

      function void note_request(request_type r);
         expected_match_type e;
         e.hit = predict_match(r);
         e.seq = accepted;
         accepted++;
         if (r.cmd != wspm_pkg::CMD_NOP)
            handled++;
         expected_hits.push_back(e);
      endfunction

      function void check_result(logic got);
         expected_match_type e;
         if (expected_hits.size() == 0) begin
            flag("result transfer with no command outstanding");
            return;
         end
         e = expected_hits.pop_front();
         if (got !== e.hit)
            flag($sformatf("command %0d: matched expected %0b, got %0b", e.seq, e.hit, got));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = wspm_pkg::CMD_NOP;
   logic [wspm_pkg::TIDX_W-1:0] req_token_index = '0;
   logic [wspm_pkg::CHAR_W-1:0] req_token_char = '0;
   logic req_token_any = 1'b0;
   logic req_token_star = 1'b0;
   logic [wspm_pkg::CHAR_W-1:0] req_text_char = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_matched;
   logic csr_wr_en = 1'b0;
   logic [wspm_pkg::COUNT_W-1:0] csr_wr_data = '0;

   // Controls shared between the stimulus and the receiver.
   logic no_idle = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   match_scoreboard sb;

   wildcard_star_pattern_matcher i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_token_index (req_token_index),
      .req_token_char  (req_token_char),
      .req_token_any   (req_token_any),
      .req_token_star  (req_token_star),
      .req_text_char   (req_text_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_matched     (rsp_matched),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, always ready while no_idle is set, and a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_matched);
   end

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 99) < 85)
         return LETTER_A + 8'($urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic request_type make_request(wspm_pkg::cmd_type c);
      request_type r;
      r.cmd = c;
      r.idx = wspm_pkg::TIDX_W'($urandom);
      r.tch = wspm_pkg::CHAR_W'($urandom);
      r.any = 1'($urandom);
      r.star = 1'($urandom);
      r.txt = wspm_pkg::CHAR_W'($urandom);
      return r;
   endfunction

   function automatic request_type load_req(int idx, logic [7:0] ch, bit any, bit star);
      request_type r;
      r = make_request(wspm_pkg::CMD_LOAD);
      r.idx = wspm_pkg::TIDX_W'(idx);
      r.tch = ch;
      r.any = any;
      r.star = star;
      return r;
   endfunction

   function automatic request_type text_req(logic [7:0] ch);
      request_type r;
      r = make_request(wspm_pkg::CMD_TEXT);
      r.txt = ch;
      return r;
   endfunction

   // A text for the first n tokens: mostly one that matches, sometimes damaged,
   // otherwise random letters.
   function automatic text_type make_text(int n);
      text_type t;
      int reps;
      int pos;
      if ($urandom_range(0, 99) < 60) begin
         for (int i = 0; i < n; i++) begin
            reps = sb.tok_star[i] ? $urandom_range(0, 3) : 1;
            repeat (reps)
               t.push_back(sb.tok_any[i] ? pick_char() : sb.tok_char[i]);
         end
         if ($urandom_range(0, 99) < 30) begin
            pos = $urandom_range(0, t.size());
            case ($urandom_range(0, 2))
               0: t.insert(pos, pick_char());
               1: if (pos < t.size()) t[pos] = pick_char();
               default: if (pos < t.size()) t.delete(pos);
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 8))
            t.push_back(pick_char());
      end
      return t;
   endfunction

   // Offers one command and returns at the edge of its transfer.
   task automatic send(request_type r);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_token_index <= r.idx;
      req_token_char <= r.tch;
      req_token_any <= r.any;
      req_token_star <= r.star;
      req_text_char <= r.txt;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_request(r);
   endtask

   // Stray commands: a no-op, a token reload, or a restart in mid-text.
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send(make_request(wspm_pkg::CMD_NOP));
         1: send(make_request(wspm_pkg::CMD_LOAD));
         default: send(make_request(wspm_pkg::CMD_START));
      endcase
   endtask

   task automatic play_text(text_type chars, bit fresh);
      if (fresh)
         send(make_request(wspm_pkg::CMD_START));
      foreach (chars[k]) begin
         if ($urandom_range(0, 99) < 6)
            send_noise();
         send(text_req(chars[k]));
      end
   endtask

   // Stops offering and waits until every outstanding result has come back.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending() != 0)
         sb.flag($sformatf("%0d results never arrived", sb.pending()));
   endtask

   task automatic write_count(logic [wspm_pkg::COUNT_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_token_count(v);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      request_type r;
      int unsigned goal;
      int len;
      int cnt;
      int n;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // With no tokens in use: text before any start, an all-ones no-op, the empty pattern.
      send(text_req(8'hFF));
      r = make_request(wspm_pkg::CMD_NOP);
      r.idx = '1;
      r.tch = '1;
      r.any = 1'b1;
      r.star = 1'b1;
      r.txt = '1;
      send(r);
      send(make_request(wspm_pkg::CMD_START));
      send(text_req(8'h00));

      // Pattern "a*.b", plus the last slot and a zero character.
      send(load_req(0, "a", 0, 1));
      send(load_req(1, 8'h00, 1, 0));
      send(load_req(2, "b", 0, 0));
      send(load_req(SLOTS - 1, 8'hFF, 1, 1));
      send(load_req(3, 8'h00, 0, 0));
      write_count(wspm_pkg::COUNT_W'(3));
      send(make_request(wspm_pkg::CMD_START));
      send(text_req("x"));
      send(text_req("b"));
      send(text_req("b"));
      send(make_request(wspm_pkg::CMD_START));
      send(text_req("a"));
      send(text_req("a"));
      send(text_req("z"));
      send(text_req("b"));

      // A token reloaded in the middle of a text takes effect at once.
      send(make_request(wspm_pkg::CMD_START));
      send(text_req("a"));
      send(load_req(2, "c", 0, 0));
      send(text_req("q"));
      send(text_req("c"));

      // Random phases: load a pattern, set the count while idle, then run texts.
      // The hold-off phase always loads a full pattern so the input side backs up.
      goal = sb.handled + RANDOM_ITEMS;
      for (int p = 0; sb.handled < goal; p++) begin
         if (p == 3)
            hold_requests <= hold_requests + 1;
         no_idle <= (p == 6 || p == 7);
         if (p < 2 || p == 3 || $urandom_range(0, 9) == 0)
            len = SLOTS;
         else
            len = $urandom_range(0, 8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 5)
               send(make_request(wspm_pkg::CMD_NOP));
            send(load_req(i, pick_char(), $urandom_range(0, 99) < 25,
                          $urandom_range(0, 99) < 35));
         end
         // The count usually matches the tokens loaded in this phase but may exceed them, up to 63.
         cnt = len;
         if (p == 0)
            cnt = 63;
         else if (p == 2)
            cnt = 0;
         else if (len == SLOTS && $urandom_range(0, 3) == 0)
            cnt = $urandom_range(SLOTS + 1, 63);
         else if ($urandom_range(0, 4) == 0)
            cnt = $urandom_range(0, len);
         write_count(wspm_pkg::COUNT_W'(cnt));
         n = (cnt > SLOTS) ? SLOTS : cnt;
         // The first text sometimes carries on from the previous phase without a start.
         for (int t = 0; t < int'($urandom_range(3, 6)); t++)
            play_text(make_text(n), !(t == 0 && $urandom_range(0, 2) == 0));
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("wildcard_star_pattern_matcher_tb: clean");
      else
         $display("wildcard_star_pattern_matcher_tb: errors");
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #2_000_000;
      $display("wildcard_star_pattern_matcher_tb: errors");
      $finish;
   end

endmodule

>>> wildcard_star_pattern_matcher.f
+incdir+sv
sv/wspm_pkg.sv
sv/wspm_token_table.sv
sv/wspm_closure.sv
sv/wspm_match_core.sv
sv/wildcard_star_pattern_matcher.sv
test/wildcard_star_pattern_matcher_tb.sv
